// ===== design/ille_pkg.sv =====
// shared types and constants for the indexed linked list engine
package ille_pkg;

  localparam int CMD_W  = 2;
  localparam int POS_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 5;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ERASE    = 2'd1,
    CMD_TRAVERSE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 3'd0,
    ST_BADPOS = 3'd1,
    ST_FULL   = 3'd2,
    ST_ELEM   = 3'd3,
    ST_EMPTY  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_FREE,
    S_WALK,
    S_FIN_A,
    S_FIN_B,
    S_TRAV,
    S_RESP
  } state_t;

endpackage

// ===== design/ille_link_ram.sv =====
// link memory: one registered read port, one write port, reset contents chained as free list
module ille_link_ram #(
  parameter int CAPACITY = 16,
  parameter int SW       = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [SW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [SW-1:0] wr_data
);

  logic [SW-1:0]       mem [CAPACITY];
  logic [CAPACITY-1:0] vld;
  logic [SW-1:0]       rd_q;
  logic [SW-1:0]       rd_addr_q;
  logic                rd_vld_q;
  logic [SW-1:0]       reset_link;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q      <= mem[rd_addr];
      rd_addr_q <= rd_addr;
      rd_vld_q  <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // an entry never written reads as its place in the initial free chain
  always_comb begin
    if (rd_addr_q == SW'(CAPACITY - 1)) begin
      reset_link = '0;
    end else begin
      reset_link = rd_addr_q + SW'(1);
    end
  end

  assign rd_data = rd_vld_q ? rd_q : reset_link;

endmodule

// ===== design/indexed_linked_list_engine_top.sv =====
// top level of the indexed linked list engine
//
// A bounded singly linked list of signed 32-bit values, kept in a value
// memory and a link memory, with unused slots chained in a free list.
// Commands arrive on the s_axis channel: insert at a position, erase at a
// position, or traverse. Results leave on the m_axis channel through an
// output register; tlast marks the final result of a command.
// Insert and erase give one result each: the link memory is read once per
// cycle while the list is walked from the head to the position, then one
// or two link writes finish the update. Bad positions, a full store, an
// empty traverse and the unused command answer without a list walk. A
// traverse of n entries emits n results, one per cycle while m_axis_tready
// allows, each link read feeding the next read address.
// One command is worked on at a time; s_axis_tready is high only while
// the sequencer waits for a command.
// Reset empties the list and chains every slot into the free list at
// once; no clearing pass is needed. When m_axis_tready is low the pending
// result holds and the sequencer waits before giving another.
module indexed_linked_list_engine_top #(
  parameter int CAPACITY = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [1:0] command, [9:2] position, [41:10] item_value, [47:42] zero
  input  logic [ille_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status, [34:3] element_value, [39:35] element_count
  output logic [ille_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  output logic                            m_axis_tlast
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ille_pkg::state_t  state, state_next;

  logic [ille_pkg::CMD_W-1:0]  in_command;
  logic signed [ille_pkg::POS_W-1:0] in_position;
  logic signed [ille_pkg::VAL_W-1:0] in_value;

  ille_pkg::cmd_t cmd_q, cmd_next;
  logic signed [ille_pkg::VAL_W-1:0] val_q, val_next;
  logic [CW-1:0] steps, steps_next;
  logic          pos_zero, pos_zero_next;
  logic [SW-1:0] a0, a0_next;
  logic [SW-1:0] a1, a1_next;
  logic [SW-1:0] ns, ns_next;
  logic [SW-1:0] head, head_next;
  logic [SW-1:0] free_head, free_head_next;
  logic [CW-1:0] count, count_next;
  ille_pkg::status_t res_status, res_status_next;

  logic                               out_valid, out_valid_next;
  ille_pkg::status_t                  out_status, out_status_next;
  logic signed [ille_pkg::VAL_W-1:0]  out_value, out_value_next;
  logic [ille_pkg::CNT_W-1:0]         out_count, out_count_next;
  logic                               out_last, out_last_next;

  logic          lrd_en;
  logic [SW-1:0] lrd_addr;
  logic [SW-1:0] link_rd;
  logic          lwr_en;
  logic [SW-1:0] lwr_addr;
  logic [SW-1:0] lwr_data;

  logic                              vrd_en;
  logic                              vwr_en;
  logic signed [ille_pkg::VAL_W-1:0] value_mem [CAPACITY];
  logic signed [ille_pkg::VAL_W-1:0] value_rd;

  logic [7:0]    pos_ext;
  logic [7:0]    cnt_ext;
  logic [CW-1:0] pos_cnt;
  logic          ins_bad;
  logic          ers_bad;
  logic          is_full;
  logic          out_free;

  assign in_command  = s_axis_tdata[1:0];
  assign in_position = s_axis_tdata[9:2];
  assign in_value    = s_axis_tdata[41:10];

  assign pos_ext = {1'b0, in_position[6:0]};
  assign cnt_ext = 8'(count);
  assign pos_cnt = CW'(in_position[6:0]);
  assign ins_bad = in_position[7] || (pos_ext > cnt_ext);
  assign ers_bad = in_position[7] || (pos_ext >= cnt_ext);
  assign is_full = (count == CW'(CAPACITY));
  assign out_free = !out_valid || m_axis_tready;

  ille_link_ram #(
    .CAPACITY(CAPACITY),
    .SW      (SW)
  ) u_link_ram (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (lrd_en),
    .rd_addr(lrd_addr),
    .rd_data(link_rd),
    .wr_en  (lwr_en),
    .wr_addr(lwr_addr),
    .wr_data(lwr_data)
  );

  always_ff @(posedge clk) begin
    if (vwr_en) begin
      value_mem[ns] <= val_q;
    end
    if (vrd_en) begin
      value_rd <= value_mem[lrd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ille_pkg::S_IDLE;
      head      <= '0;
      free_head <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      free_head <= free_head_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q      <= cmd_next;
    val_q      <= val_next;
    steps      <= steps_next;
    pos_zero   <= pos_zero_next;
    a0         <= a0_next;
    a1         <= a1_next;
    ns         <= ns_next;
    res_status <= res_status_next;
    out_status <= out_status_next;
    out_value  <= out_value_next;
    out_count  <= out_count_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    cmd_next        = cmd_q;
    val_next        = val_q;
    steps_next      = steps;
    pos_zero_next   = pos_zero;
    a0_next         = a0;
    a1_next         = a1;
    ns_next         = ns;
    head_next       = head;
    free_head_next  = free_head;
    count_next      = count;
    res_status_next = res_status;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_value_next  = out_value;
    out_count_next  = out_count;
    out_last_next   = out_last;
    lrd_en          = 1'b0;
    lrd_addr        = link_rd;
    vrd_en          = 1'b0;
    lwr_en          = 1'b0;
    lwr_addr        = a1;
    lwr_data        = ns;
    vwr_en          = 1'b0;
    s_axis_tready   = (state == ille_pkg::S_IDLE);

    case (state)
      ille_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_next      = ille_pkg::cmd_t'(in_command);
          val_next      = in_value;
          pos_zero_next = (in_position == '0);
          steps_next    = pos_cnt;
          case (ille_pkg::cmd_t'(in_command))
            ille_pkg::CMD_INSERT: begin
              if (ins_bad) begin
                res_status_next = ille_pkg::ST_BADPOS;
                state_next      = ille_pkg::S_RESP;
              end else if (is_full) begin
                res_status_next = ille_pkg::ST_FULL;
                state_next      = ille_pkg::S_RESP;
              end else begin
                lrd_en     = 1'b1;
                lrd_addr   = free_head;
                ns_next    = free_head;
                state_next = ille_pkg::S_INS_FREE;
              end
            end
            ille_pkg::CMD_ERASE: begin
              if (ers_bad) begin
                res_status_next = ille_pkg::ST_BADPOS;
                state_next      = ille_pkg::S_RESP;
              end else begin
                // first read is the head; position p needs p more reads
                lrd_en   = 1'b1;
                lrd_addr = head;
                a1_next  = head;
                if (in_position == '0) begin
                  state_next = ille_pkg::S_FIN_A;
                end else begin
                  state_next = ille_pkg::S_WALK;
                end
              end
            end
            ille_pkg::CMD_TRAVERSE: begin
              if (count == '0) begin
                res_status_next = ille_pkg::ST_EMPTY;
                state_next      = ille_pkg::S_RESP;
              end else begin
                lrd_en     = 1'b1;
                vrd_en     = 1'b1;
                lrd_addr   = head;
                steps_next = count;
                state_next = ille_pkg::S_TRAV;
              end
            end
            default: begin
              res_status_next = ille_pkg::ST_DONE;
              state_next      = ille_pkg::S_RESP;
            end
          endcase
        end
      end

      ille_pkg::S_INS_FREE: begin
        // link_rd is the successor of the claimed free slot
        free_head_next = link_rd;
        vwr_en         = 1'b1;
        if (steps == '0) begin
          lwr_en          = 1'b1;
          lwr_addr        = ns;
          lwr_data        = head;
          head_next       = ns;
          count_next      = count + CW'(1);
          res_status_next = ille_pkg::ST_DONE;
          state_next      = ille_pkg::S_RESP;
        end else begin
          lrd_en     = 1'b1;
          lrd_addr   = head;
          a1_next    = head;
          steps_next = steps - CW'(1);
          if (steps == CW'(1)) begin
            state_next = ille_pkg::S_FIN_A;
          end else begin
            state_next = ille_pkg::S_WALK;
          end
        end
      end

      ille_pkg::S_WALK: begin
        lrd_en     = 1'b1;
        lrd_addr   = link_rd;
        a0_next    = a1;
        a1_next    = link_rd;
        steps_next = steps - CW'(1);
        if (steps == CW'(1)) begin
          state_next = ille_pkg::S_FIN_A;
        end
      end

      ille_pkg::S_FIN_A: begin
        // link_rd holds the link of slot a1
        lwr_en = 1'b1;
        if (cmd_q == ille_pkg::CMD_INSERT) begin
          lwr_addr   = ns;
          lwr_data   = link_rd;
          state_next = ille_pkg::S_FIN_B;
        end else if (pos_zero) begin
          head_next       = link_rd;
          lwr_addr        = a1;
          lwr_data        = free_head;
          free_head_next  = a1;
          count_next      = count - CW'(1);
          res_status_next = ille_pkg::ST_DONE;
          state_next      = ille_pkg::S_RESP;
        end else begin
          lwr_addr   = a0;
          lwr_data   = link_rd;
          state_next = ille_pkg::S_FIN_B;
        end
      end

      ille_pkg::S_FIN_B: begin
        lwr_en   = 1'b1;
        lwr_addr = a1;
        if (cmd_q == ille_pkg::CMD_INSERT) begin
          lwr_data   = ns;
          count_next = count + CW'(1);
        end else begin
          lwr_data       = free_head;
          free_head_next = a1;
          count_next     = count - CW'(1);
        end
        res_status_next = ille_pkg::ST_DONE;
        state_next      = ille_pkg::S_RESP;
      end

      ille_pkg::S_TRAV: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = ille_pkg::ST_ELEM;
          out_value_next  = value_rd;
          out_count_next  = ille_pkg::CNT_W'(count);
          out_last_next   = (steps == CW'(1));
          if (steps == CW'(1)) begin
            state_next = ille_pkg::S_IDLE;
          end else begin
            lrd_en     = 1'b1;
            vrd_en     = 1'b1;
            lrd_addr   = link_rd;
            steps_next = steps - CW'(1);
          end
        end
      end

      ille_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_value_next  = '0;
          out_count_next  = ille_pkg::CNT_W'(count);
          out_last_next   = 1'b1;
          state_next      = ille_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = ille_pkg::S_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_count, out_value, out_status};
  assign m_axis_tlast  = out_last;

endmodule

// ===== verif/indexed_linked_list_engine_top_tb.sv =====
// self-checking testbench for the indexed linked list engine: insert, erase and traverse streams
module indexed_linked_list_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY   = 16;
  localparam int SLOT_W     = $clog2(CAPACITY);
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    ille_pkg::status_t                status;
    logic [ille_pkg::VAL_W-1:0]       value;
    logic [ille_pkg::CNT_W-1:0]       count;
    logic                             last;
  } list_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  // [1:0] command, [9:2] position, [41:10] item_value, [47:42] zero
  logic [ille_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  // [2:0] status, [34:3] element_value, [39:35] element_count
  logic [ille_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                            m_axis_tlast;

  // shadow copy of the list
  logic [ille_pkg::VAL_W-1:0] list_val [CAPACITY];
  logic [SLOT_W-1:0]          list_link [CAPACITY];
  logic [SLOT_W-1:0]          list_head;
  logic [SLOT_W-1:0]          list_free;
  int                         list_cnt;

  list_result_t expected_results[$];
  int           err_cnt = 0;
  int           cycle_cnt = 0;
  bit           idle_on = 1'b0;

  indexed_linked_list_engine_top #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_results.size());
      $display("indexed_linked_list_engine_top_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    if (err_cnt < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, what);
    err_cnt++;
  endtask

  function automatic void push_result(ille_pkg::status_t st,
                                      logic [ille_pkg::VAL_W-1:0] v, logic l);
    list_result_t r;
    r.status = st;
    r.value  = v;
    r.count  = ille_pkg::CNT_W'(list_cnt);
    r.last   = l;
    expected_results.push_back(r);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_at(int p);
    logic [SLOT_W-1:0] s;
    s = list_head;
    for (int i = 0; i < p; i++)
      s = list_link[s];
    return s;
  endfunction

  // updates the shadow list and queues what the command should answer
  function automatic void predict_list(ille_pkg::cmd_t cmd, logic [ille_pkg::POS_W-1:0] pos,
                                       logic [ille_pkg::VAL_W-1:0] val);
    int                p;
    logic [SLOT_W-1:0] ns, prev, tgt, s;
    p = int'($signed(pos));
    case (cmd)
      ille_pkg::CMD_INSERT: begin
        if (p < 0 || p > list_cnt) begin
          push_result(ille_pkg::ST_BADPOS, '0, 1'b1);
        end else if (list_cnt >= CAPACITY) begin
          push_result(ille_pkg::ST_FULL, '0, 1'b1);
        end else begin
          ns = list_free;
          list_free = list_link[ns];
          list_val[ns] = val;
          if (p == 0) begin
            list_link[ns] = list_head;
            list_head = ns;
          end else begin
            prev = slot_at(p - 1);
            list_link[ns] = list_link[prev];
            list_link[prev] = ns;
          end
          list_cnt++;
          push_result(ille_pkg::ST_DONE, '0, 1'b1);
        end
      end
      ille_pkg::CMD_ERASE: begin
        if (p < 0 || p >= list_cnt) begin
          push_result(ille_pkg::ST_BADPOS, '0, 1'b1);
        end else begin
          if (p == 0) begin
            tgt = list_head;
            list_head = list_link[tgt];
          end else begin
            prev = slot_at(p - 1);
            tgt = list_link[prev];
            list_link[prev] = list_link[tgt];
          end
          list_link[tgt] = list_free;
          list_free = tgt;
          list_cnt--;
          push_result(ille_pkg::ST_DONE, '0, 1'b1);
        end
      end
      ille_pkg::CMD_TRAVERSE: begin
        if (list_cnt == 0) begin
          push_result(ille_pkg::ST_EMPTY, '0, 1'b1);
        end else begin
          s = list_head;
          for (int i = 0; i < list_cnt; i++) begin
            push_result(ille_pkg::ST_ELEM, list_val[s], i == list_cnt - 1);
            s = list_link[s];
          end
        end
      end
      default: push_result(ille_pkg::ST_DONE, '0, 1'b1);
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(ille_pkg::cmd_t cmd, logic [ille_pkg::POS_W-1:0] pos,
                           logic [ille_pkg::VAL_W-1:0] val);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, val, pos, cmd};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_list(cmd, pos, val);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [ille_pkg::VAL_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  // result sink with random stall bursts
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[2:0] !== want.status)
          report_mismatch($sformatf("status got %0d want %0d",
                                    m_axis_tdata[2:0], want.status));
        if (m_axis_tdata[34:3] !== want.value)
          report_mismatch($sformatf("element_value got %h want %h",
                                    m_axis_tdata[34:3], want.value));
        if (m_axis_tdata[39:35] !== want.count)
          report_mismatch($sformatf("element_count got %0d want %0d",
                                    m_axis_tdata[39:35], want.count));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast got %b want %b", m_axis_tlast, want.last));
      end
    end
  end

  task automatic test_basic_ops();
    send_item(ille_pkg::CMD_TRAVERSE, 8'd0, 32'h0);          // empty list
    send_item(ille_pkg::CMD_ERASE, 8'd0, 32'h0);             // erase on empty
    send_item(ille_pkg::CMD_INSERT, 8'hff, 32'h1234_5678);   // negative position
    send_item(ille_pkg::CMD_INSERT, 8'd1, 32'h1234_5678);    // past the end
    send_item(ille_pkg::CMD_INSERT, 8'd0, 32'h8000_0000);
    send_item(ille_pkg::CMD_INSERT, 8'd1, 32'h7fff_ffff);    // append
    send_item(ille_pkg::CMD_INSERT, 8'd1, 32'h0);            // middle
    send_item(ille_pkg::CMD_INSERT, 8'd0, 32'hffff_ffff);    // new head
    send_item(ille_pkg::CMD_TRAVERSE, 8'hff, 32'hffff_ffff);
    send_item(ille_pkg::CMD_ERASE, 8'd4, 32'h0);             // erase at count
    send_item(ille_pkg::CMD_ERASE, 8'h80, 32'h0);
    send_item(ille_pkg::CMD_INSERT, 8'h7f, 32'h5555_aaaa);
    send_item(ille_pkg::CMD_NOP, 8'($urandom), $urandom);
    send_item(ille_pkg::CMD_NOP, 8'hff, 32'hffff_ffff);
    send_item(ille_pkg::CMD_ERASE, 8'd1, 32'hffff_ffff);     // middle
    send_item(ille_pkg::CMD_ERASE, 8'd2, 32'h0);             // tail
    send_item(ille_pkg::CMD_ERASE, 8'd0, 32'h0);             // head
    send_item(ille_pkg::CMD_TRAVERSE, 8'd0, 32'h0);
    send_item(ille_pkg::CMD_INSERT, 8'd1, 32'haaaa_5555);
    send_item(ille_pkg::CMD_TRAVERSE, 8'd0, 32'h0);
  endtask

  task automatic test_full_store();
    while (list_cnt < CAPACITY)
      send_item(ille_pkg::CMD_INSERT, 8'($urandom_range(0, list_cnt)), random_value());
    send_item(ille_pkg::CMD_INSERT, 8'd5, 32'h1);
    send_item(ille_pkg::CMD_INSERT, 8'(CAPACITY), 32'h2);
    // position check wins over the full check
    send_item(ille_pkg::CMD_INSERT, 8'(CAPACITY + 1), 32'h3);
    send_item(ille_pkg::CMD_TRAVERSE, 8'd0, 32'h0);
    wait_for_results();
    send_item(ille_pkg::CMD_ERASE, 8'(CAPACITY), 32'h0);
    send_item(ille_pkg::CMD_ERASE, 8'(CAPACITY - 1), 32'h0);
    while (list_cnt > 0)
      send_item(ille_pkg::CMD_ERASE, 8'($urandom_range(0, list_cnt - 1)), $urandom);
    send_item(ille_pkg::CMD_TRAVERSE, 8'd0, 32'h0);
  endtask

  task automatic test_random_ops(int n_items);
    bit                         grow;
    int                         k;
    ille_pkg::cmd_t             c;
    logic [ille_pkg::POS_W-1:0] p;
    grow = 1'b1;
    for (int i = 0; i < n_items; i++) begin
      // one stretch without idling, and none in the last part
      idle_on = !(i >= 120 && i < 170) && (i < n_items - 50);
      if (i % 100 == 60)
        wait_for_results();
      if (list_cnt >= CAPACITY)
        grow = 1'b0;
      else if (list_cnt == 0)
        grow = 1'b1;
      else if ($urandom_range(0, 19) == 0)
        grow = !grow;
      k = $urandom_range(0, 99);
      if (k < 8) begin
        c = ille_pkg::cmd_t'($urandom_range(0, 3));
        p = 8'($urandom);
      end else if (k < 18) begin
        c = ille_pkg::CMD_TRAVERSE;
        p = 8'($urandom);
      end else if (k < 24) begin
        c = $urandom_range(0, 1) ? ille_pkg::CMD_INSERT : ille_pkg::CMD_ERASE;
        if ($urandom_range(0, 1))
          p = 8'(-1 - int'($urandom_range(0, 127)));
        else
          p = 8'(list_cnt + (c == ille_pkg::CMD_INSERT) + $urandom_range(0, 3));
      end else begin
        if ($urandom_range(0, 3) == 0)
          c = grow ? ille_pkg::CMD_ERASE : ille_pkg::CMD_INSERT;
        else
          c = grow ? ille_pkg::CMD_INSERT : ille_pkg::CMD_ERASE;
        if (c == ille_pkg::CMD_INSERT) begin
          case ($urandom_range(0, 5))
            0:       p = 8'd0;
            1:       p = 8'(list_cnt);
            default: p = 8'($urandom_range(0, list_cnt));
          endcase
        end else if (list_cnt == 0) begin
          p = 8'd0;
        end else begin
          case ($urandom_range(0, 5))
            0:       p = 8'd0;
            1:       p = 8'(list_cnt - 1);
            default: p = 8'($urandom_range(0, list_cnt - 1));
          endcase
        end
      end
      send_item(c, p, random_value());
    end
  endtask

  initial begin
    for (int i = 0; i < CAPACITY; i++) begin
      list_val[i]  = '0;
      list_link[i] = SLOT_W'((i + 1 < CAPACITY) ? i + 1 : 0);
    end
    list_head = '0;
    list_free = '0;
    list_cnt  = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    idle_on = 1'b1;

    test_basic_ops();
    test_full_store();
    test_random_ops(294);

    idle_on = 1'b0;
    wait_for_results();
    repeat (40) @(negedge clk);
    if (err_cnt == 0)
      $display("indexed_linked_list_engine_top_tb: PASS");
    else
      $display("indexed_linked_list_engine_top_tb: FAIL");
    $finish;
  end

endmodule
